/* rtl/fpr_pkg.sv */
// Shared types and constants for the fractional PLL rate planner.
`timescale 1ns / 1ps
package fpr_pkg;
	localparam int FRAC_BITS_DEF = 32;
	localparam int BAND_ENTRIES = 2;
	localparam int TARGET_W = 34;
	localparam int REF_W = 32;
	localparam int REG_FIELD_BITS = 40;
	localparam int LOW_FRAC_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA16  = 3'd0,
		REG_BAND_CNT = 3'd1,
		REG_B0_MIN   = 3'd2,
		REG_B0_MAX   = 3'd3,
		REG_B0_CODE  = 3'd4,
		REG_B1_MIN   = 3'd5,
		REG_B1_MAX   = 3'd6,
		REG_B1_CODE  = 3'd7
	} fpr_reg_t;

	typedef struct packed {
		logic                  mode;
		logic [TARGET_W-1:0]   target;
		logic [REF_W-1:0]      ref_rate;
		logic [31:0]           mult_in;
		logic [31:0]           frac_low;
		logic [7:0]            frac_high;
		logic                  frac_en;
	} fpr_side_t;

	typedef struct packed {
		logic                         alpha16;
		logic [1:0]                   band_count;
		logic [1:0][TARGET_W-1:0]     band_min;
		logic [1:0][TARGET_W-1:0]     band_max;
		logic [1:0][1:0]              band_code;
	} fpr_cfg_t;
endpackage

/* rtl/fpr_div_cell.sv */
// One restoring division step of the divider chain.
`timescale 1ns / 1ps
module fpr_div_cell import fpr_pkg::*; #(
	parameter int NUM_W = 66,
	parameter bit SPLIT = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_i,
	input  fpr_side_t        side_i,
	input  logic [REF_W-1:0] rem_i,
	input  logic [NUM_W-1:0] nq_i,
	input  logic             exact_i,
	output logic             valid_o,
	output fpr_side_t        side_o,
	output logic [REF_W-1:0] rem_o,
	output logic [NUM_W-1:0] nq_o,
	output logic             exact_o
);
	logic [REF_W:0]   rs;
	logic             ge;
	logic [REF_W-1:0] rem_n;

	assign rs = {rem_i, nq_i[NUM_W-1]};
	assign ge = rs >= {1'b0, side_i.ref_rate};
	assign rem_n = ge ? REF_W'(rs - {1'b0, side_i.ref_rate}) : rs[REF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o  <= side_i;
			rem_o   <= rem_n;
			nq_o    <= {nq_i[NUM_W-2:0], ge};
			exact_o <= SPLIT ? (rem_n == '0) : exact_i;
		end
	end
endmodule

/* rtl/fpr_rate.sv */
// Alpha rounding, rate multiply, band search and clamp stages.
`timescale 1ns / 1ps
module fpr_rate import fpr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_i,
	input  fpr_side_t                         side_i,
	input  logic [REF_W-1:0]                  rem_i,
	input  logic [TARGET_W+FRAC_BITS-1:0]     nq_i,
	input  logic                              exact_i,
	input  fpr_cfg_t                          cfg,
	output logic                              out_valid,
	output logic [31:0]                       mult_out,
	output logic [31:0]                       frac_low_out,
	output logic [7:0]                        frac_high_out,
	output logic [1:0]                        band_code,
	output logic                              in_range,
	output logic [63:0]                       out_rate
);
	localparam int AW = FRAC_BITS + 1;
	localparam int SH = REG_FIELD_BITS - FRAC_BITS;

	logic                  vld_s1, vld_s2, vld_s3;
	logic                  mode_s1, mode_s2, mode_s3;
	logic                  fix_s1, fix_s2, fix_s3;
	logic [63:0]           fixv_s1, fixv_s2, fixv_s3;
	logic [REF_W-1:0]      ref_s1;
	logic [31:0]           mult_s1, mult_s2, mult_s3;
	logic [AW-1:0]         alpha_s1, alpha_s2, alpha_s3;
	logic [63:0]           p1_s2;
	logic [REF_W+AW-1:0]   p2_s2;
	logic [63:0]           rate_s3;

	logic                  zero;
	logic [AW-1:0]         alpha_pl, alpha_rc;
	logic [REG_FIELD_BITS-1:0] rc_sh;
	logic                  two, hit0, hit1;
	logic [63:0]           lo_b, hi_b, clamped;
	logic [REG_FIELD_BITS-1:0] f40;

	assign zero = side_i.ref_rate == '0;
	assign alpha_pl = (zero || exact_i) ? '0 :
		{1'b0, nq_i[FRAC_BITS-1:0]} + AW'(rem_i != '0);
	assign rc_sh = {side_i.frac_high, side_i.frac_low} >> SH;
	always_comb begin
		if (!side_i.frac_en) begin
			alpha_rc = '0;
		end else if (cfg.alpha16) begin
			alpha_rc = AW'(side_i.frac_low[LOW_FRAC_W-1:0]);
		end else begin
			alpha_rc = rc_sh[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	assign two = (BAND_ENTRIES >= 2) && (cfg.band_count >= 2'd2);
	assign lo_b = 64'(cfg.band_min[0]);
	assign hi_b = two ? 64'(cfg.band_max[1]) : 64'(cfg.band_max[0]);
	assign hit0 = rate_s3 >= 64'(cfg.band_min[0]) && rate_s3 <= 64'(cfg.band_max[0]);
	assign hit1 = two && rate_s3 >= 64'(cfg.band_min[1])
		&& rate_s3 <= 64'(cfg.band_max[1]);
	always_comb begin
		clamped = rate_s3;
		if (clamped < lo_b) clamped = lo_b;
		if (clamped > hi_b) clamped = hi_b;
	end
	assign f40 = REG_FIELD_BITS'(alpha_s3) << SH;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= side_i.mode;
			ref_s1   <= side_i.ref_rate;
			fix_s1   <= !side_i.mode && (zero || exact_i);
			fixv_s1  <= zero ? 64'd0 : 64'(side_i.target);
			if (side_i.mode) begin
				mult_s1  <= side_i.mult_in;
				alpha_s1 <= alpha_rc;
			end else begin
				mult_s1  <= zero ? 32'd0 : nq_i[FRAC_BITS+31:FRAC_BITS];
				alpha_s1 <= alpha_pl;
			end

			mode_s2  <= mode_s1;
			fix_s2   <= fix_s1;
			fixv_s2  <= fixv_s1;
			mult_s2  <= mult_s1;
			alpha_s2 <= alpha_s1;
			p1_s2    <= 64'(ref_s1) * 64'(mult_s1);
			p2_s2    <= (REF_W+AW)'(ref_s1) * (REF_W+AW)'(alpha_s1);

			mode_s3  <= mode_s2;
			fix_s3   <= fix_s2;
			fixv_s3  <= fixv_s2;
			mult_s3  <= mult_s2;
			alpha_s3 <= alpha_s2;
			rate_s3  <= fix_s2 ? fixv_s2 : p1_s2 + 64'(p2_s2 >> FRAC_BITS);

			if (mode_s3) begin
				mult_out      <= '0;
				frac_low_out  <= '0;
				frac_high_out <= '0;
				band_code     <= '0;
				in_range      <= 1'b0;
				out_rate      <= rate_s3;
			end else begin
				mult_out <= mult_s3;
				if (cfg.alpha16) begin
					frac_low_out  <= 32'(alpha_s3[LOW_FRAC_W-1:0]);
					frac_high_out <= '0;
				end else begin
					frac_low_out  <= f40[31:0];
					frac_high_out <= f40[39:32];
				end
				in_range  <= hit0 || hit1;
				band_code <= hit0 ? cfg.band_code[0] : (hit1 ? cfg.band_code[1] : 2'd0);
				out_rate  <= (hit0 || hit1) ? rate_s3 : clamped;
			end
		end
	end
endmodule

/* rtl/fractional_pll_rate_planner_top.sv */
// Top level of the fractional PLL rate planner.
// Takes one word per cycle while the output is not stalled. The pipeline
// has one cell of the divider chain per quotient bit, then stages for
// alpha rounding, the rate multipliers, the rate sum and the band
// search. The whole pipeline holds while a finished word is stalled.
`timescale 1ns / 1ps
module fractional_pll_rate_planner_top import fpr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [33:0]           target_rate,
	input  logic [31:0]           ref_rate,
	input  logic [31:0]           mult_in,
	input  logic [31:0]           frac_low_in,
	input  logic [7:0]            frac_high_in,
	input  logic                  frac_enable_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           mult_out,
	output logic [31:0]           frac_low_out,
	output logic [7:0]            frac_high_out,
	output logic [1:0]            band_code,
	output logic                  in_range,
	output logic [63:0]           out_rate
);
	localparam int NUM_W = TARGET_W + FRAC_BITS;

	fpr_cfg_t  cfg_q;
	logic      en;
	logic      vld [NUM_W+1];
	fpr_side_t side [NUM_W+1];
	logic [REF_W-1:0] rem [NUM_W+1];
	logic [NUM_W-1:0] nq [NUM_W+1];
	logic      exact [NUM_W+1];

	assign cfg_ready = 1'b1;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha16    <= 1'b0;
			cfg_q.band_count <= 2'd1;
			cfg_q.band_min   <= '0;
			cfg_q.band_max   <= '1;
			cfg_q.band_code  <= '0;
		end else if (cfg_valid) begin
			unique case (fpr_reg_t'(cfg_index))
				REG_ALPHA16:  cfg_q.alpha16 <= cfg_data[0];
				REG_BAND_CNT: cfg_q.band_count <= cfg_data[1:0];
				REG_B0_MIN:   cfg_q.band_min[0] <= cfg_data;
				REG_B0_MAX:   cfg_q.band_max[0] <= cfg_data;
				REG_B0_CODE:  cfg_q.band_code[0] <= cfg_data[1:0];
				REG_B1_MIN:   cfg_q.band_min[1] <= cfg_data;
				REG_B1_MAX:   cfg_q.band_max[1] <= cfg_data;
				REG_B1_CODE:  cfg_q.band_code[1] <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign vld[0] = in_valid;
	assign side[0] = '{mode: mode, target: target_rate, ref_rate: ref_rate,
		mult_in: mult_in, frac_low: frac_low_in, frac_high: frac_high_in,
		frac_en: frac_enable_in};
	assign rem[0] = '0;
	assign nq[0] = {target_rate, FRAC_BITS'(0)};
	assign exact[0] = 1'b0;

	for (genvar g = 0; g < NUM_W; g++) begin : g_cell
		fpr_div_cell #(.NUM_W(NUM_W), .SPLIT(g == TARGET_W - 1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(vld[g]), .side_i(side[g]), .rem_i(rem[g]), .nq_i(nq[g]),
			.exact_i(exact[g]),
			.valid_o(vld[g+1]), .side_o(side[g+1]), .rem_o(rem[g+1]),
			.nq_o(nq[g+1]), .exact_o(exact[g+1])
		);
	end

	fpr_rate #(.FRAC_BITS(FRAC_BITS)) u_rate (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(vld[NUM_W]), .side_i(side[NUM_W]), .rem_i(rem[NUM_W]),
		.nq_i(nq[NUM_W]), .exact_i(exact[NUM_W]), .cfg(cfg_q),
		.out_valid(out_valid), .mult_out(mult_out), .frac_low_out(frac_low_out),
		.frac_high_out(frac_high_out), .band_code(band_code), .in_range(in_range),
		.out_rate(out_rate)
	);
endmodule
